// ===== rtl/shw_pkg.sv =====
package shw_pkg;

    // Fixed field widths.
    localparam int DLY_BITS     = 11;
    localparam int WET_BITS     = 17;
    localparam int YHIST_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    // Mix arithmetic: Q1.16 wet weight.
    localparam int MIX_SHIFT = 16;
    localparam logic [WET_BITS-1:0] WET_ONE = WET_BITS'(1) << MIX_SHIFT;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BLOCK_ENABLE   = 3'd0,
        CFG_DELAY_SAMPLES  = 3'd1,
        CFG_SWAP_CHANNELS  = 3'd2,
        CFG_WET_MIX        = 3'd3,
        CFG_LOWPASS_ENABLE = 3'd4,
        CFG_COEF_B0        = 3'd5,
        CFG_COEF_A1        = 3'd6,
        CFG_COEF_A2        = 3'd7
    } t_cfg_idx;

endpackage

// ===== rtl/shw_stream_if.sv =====
interface shw_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface shw_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/shw_ram.sv =====
module shw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/stereo_haas_delay_widener_unit.sv =====
// Steps, with the lowpass on: read, three filter products, filter result, mix, output;
// bypassed: read, mix, output; disabled: output. Products and mix share one multiplier.
// One item is in the engine at a time; the next is taken once the last has left output.
// Reset is synchronous and active low: registers return to their defaults, the write
// pointer, fill count and filter histories clear. Ring entries not yet written since the
// last restart read as silence through the fill count, so there is no clearing pass.
module stereo_haas_delay_widener_unit #(
    parameter int DELAY_DEPTH = 2048,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [shw_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [((COEF_BITS > shw_pkg::WET_BITS) ? COEF_BITS : shw_pkg::WET_BITS)-1:0]
                 i_cfg_data,
    shw_in_if.sink    i_in,
    shw_out_if.source o_out
);
    import shw_pkg::*;

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int FRAC = COEF_BITS - 4;
    localparam int YB   = YHIST_BITS;
    localparam int XSB  = SAMPLE_BITS + 2;
    localparam int FW   = (YB > SAMPLE_BITS) ? YB : SAMPLE_BITS;
    localparam int DB   = FW + 1;
    localparam int MA   = (COEF_BITS > WET_BITS + 1) ? COEF_BITS : WET_BITS + 1;
    localparam int MB   = (XSB > DB) ? XSB : DB;
    localparam int PW   = MA + MB;
    localparam int ACCW = PW + 2;
    localparam int MXW  = PW + 1;
    localparam int MOD_STEPS = (DLY_BITS >= AW) ? DLY_BITS - AW + 1 : 1;

    localparam logic [AW-1:0] PTR_LAST = AW'(DELAY_DEPTH - 1);

    localparam logic signed [ACCW-1:0] F_HALF = ACCW'(1) << (FRAC - 1);
    localparam logic signed [ACCW-1:0] Y_MAX_W = {{(ACCW-YB+1){1'b0}}, {(YB-1){1'b1}}};
    localparam logic signed [ACCW-1:0] Y_MIN_W = {{(ACCW-YB+1){1'b1}}, {(YB-1){1'b0}}};
    localparam logic signed [YB-1:0]   Y_MAX = {1'b0, {(YB-1){1'b1}}};
    localparam logic signed [YB-1:0]   Y_MIN = {1'b1, {(YB-1){1'b0}}};

    localparam logic signed [MXW-1:0] M_HALF = MXW'(WET_ONE >> 1);
    localparam logic signed [MXW-1:0] S_MAX_W =
        {{(MXW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [MXW-1:0] S_MIN_W =
        {{(MXW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_FB0, S_FA1, S_FA2, S_FY, S_MX, S_OUT
    } t_state;

    // Delay length reduced modulo the ring depth by restoring subtraction.
    function automatic logic [AW-1:0] delay_mod(input logic [DLY_BITS-1:0] d);
        int v;
        v = int'(d);
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (v >= (DELAY_DEPTH << k)) begin
                v = v - (DELAY_DEPTH << k);
            end
        end
        return AW'(v);
    endfunction

    t_state r_state;

    // Configuration.
    logic                        r_enable;
    logic [DLY_BITS-1:0]         r_delay;
    logic [AW-1:0]               r_dmod;
    logic                        r_swap;
    logic [WET_BITS-1:0]         r_wet;
    logic                        r_lp_en;
    logic signed [COEF_BITS-1:0] r_b0;
    logic signed [COEF_BITS-1:0] r_a1;
    logic signed [COEF_BITS-1:0] r_a2;

    // Ring bookkeeping and filter state.
    logic [AW-1:0]                 r_wp;
    logic [AW-1:0]                 r_fill;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [SAMPLE_BITS-1:0] r_x2;
    logic signed [YB-1:0]          r_y1;
    logic signed [YB-1:0]          r_y2;

    // Item datapath.
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic signed [SAMPLE_BITS-1:0] r_own;
    logic                          r_bypass;
    logic                          r_hit;
    logic                          r_dzero;
    logic signed [XSB-1:0]         r_xs;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACCW-1:0]        r_acc;
    logic signed [FW-1:0]          r_filt;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;

    logic                          in_fire;
    logic                          out_free;
    logic                          cfg_clear;
    logic signed [SAMPLE_BITS-1:0] own_in;
    logic [AW-1:0]                 rp;
    logic [AW:0]                   rp_wrap;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] ring;
    logic signed [XSB-1:0]         xs;
    logic [WET_BITS-1:0]           wet_eff;
    logic signed [DB-1:0]          diff;
    logic signed [MA-1:0]          m_a;
    logic signed [MB-1:0]          m_b;
    logic signed [PW-1:0]          prod;
    logic signed [ACCW-1:0]        flt_sum;
    logic signed [ACCW-1:0]        flt_sh;
    logic signed [YB-1:0]          y_sat;
    logic signed [MXW-1:0]         mix_sum;
    logic signed [MXW-1:0]         mix_sh;
    logic signed [SAMPLE_BITS-1:0] mix_sat;

    assign i_in.ready      = (r_state == S_IDLE);
    assign in_fire         = i_in.valid && i_in.ready;
    assign out_free        = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;

    // The delayed channel is the right one unless the roles are swapped.
    assign own_in = r_swap ? i_in.left_in : i_in.right_in;

    assign rp_wrap = {1'b0, r_wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, r_dmod};
    assign rp      = (r_wp >= r_dmod) ? (r_wp - r_dmod) : rp_wrap[AW-1:0];

    shw_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_fire && r_enable),
        .i_waddr (r_wp),
        .i_wdata (own_in),
        .i_raddr (rp),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cfg_clear = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BLOCK_ENABLE:  cfg_clear = i_cfg_data[0] && !r_enable;
                CFG_DELAY_SAMPLES: cfg_clear = (i_cfg_data[DLY_BITS-1:0] != r_delay);
                CFG_SWAP_CHANNELS: cfg_clear = (i_cfg_data[0] != r_swap);
                default:           cfg_clear = 1'b0;
            endcase
        end
    end

    always_comb begin
        // A zero delay returns the item being written; entries not written since the
        // last restart are silence.
        if (r_dzero) begin
            ring = r_own;
        end else if (r_hit) begin
            ring = $signed(ram_rdata);
        end else begin
            ring = '0;
        end
        xs = XSB'(ring) + (XSB'(r_x1) <<< 1) + XSB'(r_x2);

        wet_eff = (r_wet > WET_ONE) ? WET_ONE : r_wet;
        diff    = DB'(r_filt) - DB'(r_own);

        case (r_state)
            S_FB0: begin
                m_a = MA'(r_b0);
                m_b = MB'(r_xs);
            end
            S_FA1: begin
                m_a = MA'(r_a1);
                m_b = MB'(r_y1);
            end
            S_FA2: begin
                m_a = MA'(r_a2);
                m_b = MB'(r_y2);
            end
            S_MX: begin
                m_a = MA'($signed({1'b0, wet_eff}));
                m_b = MB'(diff);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        prod = m_a * m_b;

        flt_sum = r_acc - ACCW'(r_prod);
        flt_sh  = flt_sum >>> FRAC;
        if (flt_sh > Y_MAX_W) begin
            y_sat = Y_MAX;
        end else if (flt_sh < Y_MIN_W) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = YB'(flt_sh);
        end

        // own + wet * (filtered - own), in Q1.16 with round half up.
        mix_sum = (MXW'(r_own) <<< MIX_SHIFT) + MXW'(r_prod) + M_HALF;
        mix_sh  = mix_sum >>> MIX_SHIFT;
        if (mix_sh > S_MAX_W) begin
            mix_sat = S_MAX;
        end else if (mix_sh < S_MIN_W) begin
            mix_sat = S_MIN;
        end else begin
            mix_sat = SAMPLE_BITS'(mix_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_delay     <= '0;
            r_dmod      <= '0;
            r_swap      <= 1'b0;
            r_wet       <= WET_ONE >> 1;
            r_lp_en     <= 1'b0;
            r_b0        <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            // The output step reloads the result register itself.
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_left  <= i_in.left_in;
                        r_right <= i_in.right_in;
                        r_own   <= own_in;
                        if (r_enable) begin
                            r_bypass <= 1'b0;
                            r_dzero  <= (r_dmod == '0);
                            r_hit    <= (r_dmod <= r_fill);
                            r_wp     <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
                            if (r_fill != PTR_LAST) begin
                                r_fill <= r_fill + 1'b1;
                            end
                            r_state <= S_RD;
                        end else begin
                            r_bypass <= 1'b1;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    if (r_lp_en) begin
                        r_xs    <= xs;
                        r_x1    <= ring;
                        r_x2    <= r_x1;
                        r_state <= S_FB0;
                    end else begin
                        r_filt  <= FW'(ring);
                        r_state <= S_MX;
                    end
                end
                S_FB0: begin
                    r_prod  <= prod;
                    r_state <= S_FA1;
                end
                S_FA1: begin
                    r_prod  <= prod;
                    r_acc   <= ACCW'(r_prod) + F_HALF;
                    r_state <= S_FA2;
                end
                S_FA2: begin
                    r_prod  <= prod;
                    r_acc   <= r_acc - ACCW'(r_prod);
                    r_state <= S_FY;
                end
                S_FY: begin
                    r_y1    <= y_sat;
                    r_y2    <= r_y1;
                    r_filt  <= FW'(y_sat);
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_prod  <= prod;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_bypass) begin
                            r_out_left  <= r_left;
                            r_out_right <= r_right;
                        end else if (r_swap) begin
                            r_out_left  <= mix_sat;
                            r_out_right <= r_right;
                        end else begin
                            r_out_left  <= r_left;
                            r_out_right <= mix_sat;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BLOCK_ENABLE:   r_enable <= i_cfg_data[0];
                    CFG_DELAY_SAMPLES: begin
                        r_delay <= i_cfg_data[DLY_BITS-1:0];
                        r_dmod  <= delay_mod(i_cfg_data[DLY_BITS-1:0]);
                    end
                    CFG_SWAP_CHANNELS:  r_swap  <= i_cfg_data[0];
                    CFG_WET_MIX:        r_wet   <= i_cfg_data[WET_BITS-1:0];
                    CFG_LOWPASS_ENABLE: r_lp_en <= i_cfg_data[0];
                    CFG_COEF_B0:        r_b0    <= $signed(i_cfg_data[COEF_BITS-1:0]);
                    CFG_COEF_A1:        r_a1    <= $signed(i_cfg_data[COEF_BITS-1:0]);
                    CFG_COEF_A2:        r_a2    <= $signed(i_cfg_data[COEF_BITS-1:0]);
                    default: begin
                    end
                endcase
            end

            // A restart empties the ring by resetting the fill count.
            if (cfg_clear) begin
                r_wp   <= '0;
                r_fill <= '0;
                r_x1   <= '0;
                r_x2   <= '0;
                r_y1   <= '0;
                r_y2   <= '0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Until the fill count saturates, the write pointer and the fill count move together.
    a_fill_tracks_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != PTR_LAST) |-> (r_wp == r_fill))
        else $error("fill count and write pointer disagree");

    // Each item taken while enabled advances the write pointer by one entry.
    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_enable && !i_cfg_we) |=>
        (r_wp == (($past(r_wp) == PTR_LAST) ? '0 : $past(r_wp) + 1'b1)))
        else $error("write pointer did not advance by one");

    // A result only appears from the output step of the sequencer.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output became valid outside the output step");
`endif

endmodule
